[rtl/core/isc_pkg.sv]
// Shared constants and control structures for the insertion sorter.
// Used by isc_cell, isc_tally and the insertion_sort_shift_count top level.
`default_nettype none

package isc_pkg;

  // Default batch capacity and value width.
  localparam int unsigned DEF_CAPACITY   = 16;
  localparam int unsigned DEF_VALUE_BITS = 32;

  // The shift count is a fixed 7-bit field that saturates at its top value.
  localparam int unsigned SHIFT_BITS = 7;
  localparam logic [SHIFT_BITS-1:0] SHIFT_MAX = '1;

  // Per-cell control, computed once in the top level for each cell.
  typedef struct packed {
    logic insert;   // a new key enters the chain this cycle
    logic pop;      // the chain moves one place toward cell 0
    logic in_use;   // this cell holds a stored value
    logic at_slot;  // this cell is the first free cell
  } cell_ctrl_t;

  // Control for the shift tally.
  typedef struct packed {
    logic capture;  // take the compare vector of this cycle's insertion
    logic clear;    // start a new batch count
  } tally_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/isc_cell.sv]
// One cell of the insertion chain: holds a stored value, compares it with the key.
// Depends on isc_pkg for the cell control structure.
`default_nettype none

module isc_cell #(
  parameter int unsigned VALUE_BITS = isc_pkg::DEF_VALUE_BITS
) (
  input  wire logic                   clk,
  input  wire isc_pkg::cell_ctrl_t    ctrl,
  input  wire logic [VALUE_BITS-1:0]  key,
  input  wire logic                   prev_gt,
  input  wire logic [VALUE_BITS-1:0]  prev_val,
  input  wire logic [VALUE_BITS-1:0]  next_val,
  output logic      [VALUE_BITS-1:0]  val,
  output logic                        gt
);
  import isc_pkg::*;

  logic [VALUE_BITS-1:0] val_r;
  logic [VALUE_BITS-1:0] val_nxt;

  // Strictly greater only, so equal values keep their order.
  assign gt  = ctrl.in_use && ($signed(key) < $signed(val_r));
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctrl.insert) begin
      if (prev_gt) begin
        val_nxt = prev_val;
      end else if (gt || ctrl.at_slot) begin
        val_nxt = key;
      end
    end else if (ctrl.pop) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

`default_nettype wire

[rtl/core/isc_tally.sv]
// Shift tally: counts the cells moved by each insertion, saturating at the field maximum.
// Depends on isc_pkg for the tally control structure and the count width.
`default_nettype none

module isc_tally #(
  parameter int unsigned CAPACITY = isc_pkg::DEF_CAPACITY
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire isc_pkg::tally_ctrl_t              ctrl,
  input  wire logic [CAPACITY-1:0]               gt_vec,
  output logic      [isc_pkg::SHIFT_BITS-1:0]    shift_total
);
  import isc_pkg::*;

  localparam int unsigned PC_W  = $clog2(CAPACITY + 1);
  localparam int unsigned SUM_W = SHIFT_BITS + 1;

  logic [CAPACITY-1:0]   gt_vec_r;
  logic [CAPACITY-1:0]   gt_vec_nxt;
  logic [SHIFT_BITS-1:0] count_r;
  logic [SHIFT_BITS-1:0] count_nxt;
  logic [PC_W-1:0]       moved;
  logic [SUM_W-1:0]      sum;

  // The compare vector is registered first and counted in the following cycle.
  always_comb begin
    moved = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      moved = moved + PC_W'(gt_vec_r[i]);
    end
  end

  assign sum        = SUM_W'(count_r) + SUM_W'(moved);
  assign gt_vec_nxt = ctrl.capture ? gt_vec : '0;

  always_comb begin
    if (ctrl.clear) begin
      count_nxt = '0;
    end else if (sum > SUM_W'(SHIFT_MAX)) begin
      count_nxt = SHIFT_MAX;
    end else begin
      count_nxt = sum[SHIFT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gt_vec_r <= '0;
      count_r  <= '0;
    end else begin
      gt_vec_r <= gt_vec_nxt;
      count_r  <= count_nxt;
    end
  end

  assign shift_total = count_r;

endmodule

`default_nettype wire

[rtl/core/insertion_sort_shift_count.sv]
// Insertion sorter with inversion count: top level, a chain of isc_cell and one isc_tally.
// Depends on isc_pkg, isc_cell and isc_tally.
`default_nettype none

// A batch of signed values streams in, one per transfer, and each value drops into its
// place in a row of CAPACITY cells in the cycle it arrives, so the input side takes one
// transfer per clock while the batch fills. Every stored value that moves up to make room
// counts as one shift; the total is the batch's inversion count and saturates at 127.
// Equal values are not moved, so the order is stable. The transfer with in_tlast high
// closes the batch. A settle state follows, in which the last insertion's moves are
// added to the count, and then the cells shift toward cell 0 and present the batch in
// ascending order, one result per out_tready cycle, with out_tlast on the largest value.
// in_tready stays low from the closing transfer until the last result has
// been taken. Values that arrive while all CAPACITY cells are occupied are dropped and
// set the overflow flag on every result of that batch; a dropped closing value still
// closes the batch. Count and flag restart with the next batch.
module insertion_sort_shift_count #(
  parameter  int unsigned CAPACITY   = isc_pkg::DEF_CAPACITY,
  parameter  int unsigned VALUE_BITS = isc_pkg::DEF_VALUE_BITS,
  localparam int unsigned TDATA_W    = ((VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W      = ((VALUE_BITS + isc_pkg::SHIFT_BITS + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // Input stream.
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // [VALUE_BITS-1:0] sample_value, rest unused
  input  wire logic               in_tlast,   // batch_end
  // Result stream.
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [OUT_W-1:0]   out_tdata,  // sorted_value, then shift_total, zero above
  output logic                    out_tuser,  // batch_overflow
  output logic                    out_tlast   // final_result
);
  import isc_pkg::*;

  localparam int unsigned FILL_W = $clog2(CAPACITY + 1);

  // Sequencer states, one-hot.
  typedef enum logic [2:0] {
    ST_FILL   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t              state_r;
  state_t              state_nxt;
  logic [FILL_W-1:0]   fill_r;
  logic [FILL_W-1:0]   fill_nxt;
  logic                ovf_r;
  logic                ovf_nxt;

  logic                in_xfer;
  logic                out_xfer;
  logic                full;
  logic                insert;
  logic                last_pop;
  logic [VALUE_BITS-1:0] key;

  logic [VALUE_BITS-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]   cell_gt;
  cell_ctrl_t            cell_ctrl [CAPACITY];
  tally_ctrl_t           tally_ctrl;
  logic [SHIFT_BITS-1:0] shift_total;

  assign in_tready  = (state_r == ST_FILL);
  assign out_tvalid = (state_r == ST_EMIT);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_tvalid && out_tready;
  assign full       = (fill_r == FILL_W'(CAPACITY));
  assign insert     = in_xfer && !full;
  assign last_pop   = out_xfer && (fill_r == FILL_W'(1));
  assign key        = in_tdata[VALUE_BITS-1:0];

  // The cells below fill_r hold the batch in ascending order. During emission the
  // whole row moves down one place per output transfer, so cell 0 always holds the
  // next result.
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                  prev_gt;
      logic [VALUE_BITS-1:0] prev_val;
      logic [VALUE_BITS-1:0] next_val;

      if (i == 0) begin : g_head
        assign prev_gt  = 1'b0;
        assign prev_val = '0;
      end else begin : g_body
        assign prev_gt  = cell_gt[i-1];
        assign prev_val = cell_val[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign next_val = '0;
      end else begin : g_link
        assign next_val = cell_val[i+1];
      end

      assign cell_ctrl[i].insert  = insert;
      assign cell_ctrl[i].pop     = out_xfer;
      assign cell_ctrl[i].in_use  = (FILL_W'(i) < fill_r);
      assign cell_ctrl[i].at_slot = (FILL_W'(i) == fill_r);

      isc_cell #(
        .VALUE_BITS (VALUE_BITS)
      ) u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl[i]),
        .key      (key),
        .prev_gt  (prev_gt),
        .prev_val (prev_val),
        .next_val (next_val),
        .val      (cell_val[i]),
        .gt       (cell_gt[i])
      );
    end
  endgenerate

  // Every cell whose value is greater than the key moves up by one place, so the
  // number of set compare bits is the number of shifts of this insertion.
  assign tally_ctrl.capture = insert;
  assign tally_ctrl.clear   = last_pop;

  isc_tally #(
    .CAPACITY (CAPACITY)
  ) u_tally (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (tally_ctrl),
    .gt_vec      (cell_gt),
    .shift_total (shift_total)
  );

  // Sequencer, fill count and overflow flag.
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      ST_FILL: begin
        if (insert) begin
          fill_nxt = fill_r + FILL_W'(1);
        end
        if (in_xfer && full) begin
          ovf_nxt = 1'b1;
        end
        if (in_xfer && in_tlast) begin
          state_nxt = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_xfer) begin
          fill_nxt = fill_r - FILL_W'(1);
        end
        if (last_pop) begin
          ovf_nxt   = 1'b0;
          state_nxt = ST_FILL;
        end
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      fill_r  <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Results come straight from cell 0 and the batch registers.
  assign out_tdata = OUT_W'({shift_total, cell_val[0]});
  assign out_tuser = ovf_r;
  assign out_tlast = (fill_r == FILL_W'(1));

`ifndef NO_ASSERTIONS
  // The two sides never run at once.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output active in the same cycle");

  // Emission always has a stored value to present.
  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (fill_r != '0))
    else $error("emission with an empty chain");

  // The fill count never passes the number of cells.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(CAPACITY))
    else $error("fill count beyond capacity");

  // After the final result the block is ready for a new, empty batch.
  a_batch_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast) |=> (in_tready && (fill_r == '0) && !ovf_r))
    else $error("batch state not cleared after final result");
`endif

endmodule

`default_nettype wire
